// ===== design/rotated_quad_bounding_box_defines.svh =====
// Assertion macros used by the rotated quad bounding box top level.
`ifndef ROTATED_QUAD_BOUNDING_BOX_DEFINES_SVH
`define ROTATED_QUAD_BOUNDING_BOX_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RQBB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RQBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rqbb_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table.
package rqbb_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CS_W         = 18;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [CS_W-1:0] co;
        logic signed [CS_W-1:0] si;
    } cs_t;

    function automatic logic signed [33:0] atan_turn(input logic [3:0] idx);
        logic signed [33:0] v;
        case (idx)
            4'd0:    v = 34'sd536870912;
            4'd1:    v = 34'sd316933406;
            4'd2:    v = 34'sd167458907;
            4'd3:    v = 34'sd85004756;
            4'd4:    v = 34'sd42667331;
            4'd5:    v = 34'sd21354465;
            4'd6:    v = 34'sd10679838;
            4'd7:    v = 34'sd5340245;
            4'd8:    v = 34'sd2670163;
            4'd9:    v = 34'sd1335087;
            4'd10:   v = 34'sd667544;
            4'd11:   v = 34'sd333772;
            4'd12:   v = 34'sd166886;
            4'd13:   v = 34'sd83443;
            4'd14:   v = 34'sd41722;
            default: v = 34'sd20861;
        endcase
        return v;
    endfunction

endpackage

// ===== design/rqbb_cordic.sv =====
// Iterative CORDIC giving cosine and sine of the turn angle, one step per cycle.
module rqbb_cordic #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [ANGLE_WIDTH-1:0] angle,
    output logic                   done,
    output rqbb_pkg::cs_t          cs
);
    import rqbb_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [1:0]         quad_reg, quad_next;
    logic [31:0]        turns;
    logic signed [33:0] dx, dy, xr, yr;
    logic signed [CS_W-1:0] c, s;

    function automatic logic signed [CS_W-1:0] sat_cs(input logic signed [33:0] v);
        logic signed [18:0] q;
        q = v[33:15];
        if (q > 19'sd32768) begin
            return 18'sd32768;
        end else if (q < -19'sd32768) begin
            return -18'sd32768;
        end
        return q[CS_W-1:0];
    endfunction

    always_comb begin
        turns     = 32'(angle) << (32 - ANGLE_WIDTH);
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quad_next = quad_reg;
        done_next = busy_reg && (cnt_reg == 4'(CORDIC_STEPS - 1));
        if (start) begin
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = {4'b0, turns[29:0]};
            quad_next = turns[31:30];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_turn(cnt_reg);
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_turn(cnt_reg);
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        quad_reg <= quad_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb begin
        xr = x_reg + 34'sd16384;
        yr = y_reg + 34'sd16384;
        c  = sat_cs(xr);
        s  = sat_cs(yr);
        case (quad_reg)
            2'd0:    begin cs.co = c;  cs.si = s;  end
            2'd1:    begin cs.co = -s; cs.si = c;  end
            2'd2:    begin cs.co = -c; cs.si = -s; end
            default: begin cs.co = s;  cs.si = -c; end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== design/rqbb_lane.sv =====
// One corner lane: scale, rotate and translate, three register stages.
module rqbb_lane #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            aclk,
    input  logic signed [COORD_WIDTH-1:0]   corner_x,
    input  logic signed [COORD_WIDTH-1:0]   corner_y,
    input  logic [15:0]                     size_scale,
    input  rqbb_pkg::cs_t                   cs,
    input  logic signed [COORD_WIDTH-1:0]   center_x,
    input  logic signed [COORD_WIDTH-1:0]   center_y,
    output logic signed [((COORD_WIDTH+9 > 49) ? 49 : COORD_WIDTH+9)+4:0] vert_x,
    output logic signed [((COORD_WIDTH+9 > 49) ? 49 : COORD_WIDTH+9)+4:0] vert_y
);
    import rqbb_pkg::*;

    localparam int SW = (COORD_WIDTH + 9 > 49) ? 49 : COORD_WIDTH + 9;
    localparam int PW = SW + CS_W;
    localparam int VW = SW + 5;

    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [PW-1:0] cx_reg, sy_s_reg, sx_s_reg, cy_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic signed [PW:0]   sum_x, sum_y;
    logic signed [VW-1:0] rot_x, rot_y;

    function automatic logic signed [SW-1:0] scale(input logic signed [COORD_WIDTH-1:0] v,
                                                    input logic [15:0] sc);
        logic signed [65:0] p;
        p = 66'(v) * $signed({50'b0, sc});
        p = (p + 66'sd128) >>> 8;
        if (p > (66'sd1 <<< 47)) begin
            p = 66'sd1 <<< 47;
        end else if (p < -(66'sd1 <<< 47)) begin
            p = -(66'sd1 <<< 47);
        end
        return p[SW-1:0];
    endfunction

    // The part-select drops the signedness, so it is restored before widening.
    always_comb begin
        sum_x = (PW+1)'(cx_reg) - (PW+1)'(sy_s_reg) + (PW+1)'(16384);
        sum_y = (PW+1)'(sx_s_reg) + (PW+1)'(cy_reg) + (PW+1)'(16384);
        rot_x = VW'($signed(sum_x[PW:15]));
        rot_y = VW'($signed(sum_y[PW:15]));
    end

    always_ff @(posedge aclk) begin
        sx_reg   <= scale(corner_x, size_scale);
        sy_reg   <= scale(corner_y, size_scale);
        cx_reg   <= PW'(cs.co) * PW'(sx_reg);
        sy_s_reg <= PW'(cs.si) * PW'(sy_reg);
        sx_s_reg <= PW'(cs.si) * PW'(sx_reg);
        cy_reg   <= PW'(cs.co) * PW'(sy_reg);
        vx_reg   <= rot_x + VW'(center_x);
        vy_reg   <= rot_y + VW'(center_y);
    end

    assign vert_x = vx_reg;
    assign vert_y = vy_reg;

endmodule

// ===== design/rotated_quad_bounding_box.sv =====
// Top level: input capture, CORDIC, three corner lanes and the running box merge.
//
// One sprite is taken at a time. An accepted beat passes through the
// iterative CORDIC (sixteen micro-rotations, one per cycle, then a registered
// completion flag), a wait state for the three parallel corner lanes, a merge
// state folding all four corners into the running box and the loading of the
// result register. The input is ready again in the cycle after that load; a
// stalled result holds the block in its output state and so holds off the
// input as well.
// The running box is saturated to the coordinate range; start_new empties it
// before the sprite merges.
module rotated_quad_bounding_box #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_start_new,
    input  logic signed [COORD_WIDTH-1:0] s_corner0_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner0_y,
    input  logic signed [COORD_WIDTH-1:0] s_corner1_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner1_y,
    input  logic signed [COORD_WIDTH-1:0] s_corner2_x,
    input  logic signed [COORD_WIDTH-1:0] s_corner2_y,
    input  logic [15:0]                   s_size_scale,
    input  logic signed [COORD_WIDTH-1:0] s_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_center_y,
    input  logic [ANGLE_WIDTH-1:0]        s_turn_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_min_x,
    output logic signed [COORD_WIDTH-1:0] m_max_x,
    output logic signed [COORD_WIDTH-1:0] m_min_y,
    output logic signed [COORD_WIDTH-1:0] m_max_y
);
    import rqbb_pkg::*;
    `include "rotated_quad_bounding_box_defines.svh"

    localparam int SW = (COORD_WIDTH + 9 > 49) ? 49 : COORD_WIDTH + 9;
    localparam int VW = SW + 5;
    localparam int EW = VW + 2;
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORDIC = 3'd1;
    localparam logic [2:0] S_LANE   = 3'd2;
    localparam logic [2:0] S_MERGE  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] wait_reg, wait_next;
    logic       start_reg;
    logic signed [COORD_WIDTH-1:0] c0x_reg, c0y_reg, c1x_reg, c1y_reg, c2x_reg, c2y_reg;
    logic signed [COORD_WIDTH-1:0] cenx_reg, ceny_reg;
    logic [15:0]            scale_reg;
    logic [ANGLE_WIDTH-1:0] angle_reg;
    logic signed [COORD_WIDTH-1:0] lox_reg, hix_reg, loy_reg, hiy_reg;
    logic signed [COORD_WIDTH-1:0] lox_next, hix_next, loy_next, hiy_next;
    logic signed [COORD_WIDTH-1:0] mlox_reg, mhix_reg, mloy_reg, mhiy_reg;
    logic       m_valid_reg, m_valid_next, load_out;
    logic       accept, cordic_done;
    cs_t        cs;
    logic signed [VW-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
    logic signed [COORD_WIDTH-1:0] px [4];
    logic signed [COORD_WIDTH-1:0] py [4];

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [EW-1:0] v);
        if (v > EW'(CMAX)) begin
            return CMAX;
        end else if (v < EW'(CMIN)) begin
            return CMIN;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    rqbb_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(accept), .angle(s_turn_angle),
        .done(cordic_done), .cs(cs)
    );

    rqbb_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane0 (
        .aclk(aclk), .corner_x(c0x_reg), .corner_y(c0y_reg), .size_scale(scale_reg),
        .cs(cs), .center_x(cenx_reg), .center_y(ceny_reg), .vert_x(v0x), .vert_y(v0y)
    );
    rqbb_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane1 (
        .aclk(aclk), .corner_x(c1x_reg), .corner_y(c1y_reg), .size_scale(scale_reg),
        .cs(cs), .center_x(cenx_reg), .center_y(ceny_reg), .vert_x(v1x), .vert_y(v1y)
    );
    rqbb_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane2 (
        .aclk(aclk), .corner_x(c2x_reg), .corner_y(c2y_reg), .size_scale(scale_reg),
        .cs(cs), .center_x(cenx_reg), .center_y(ceny_reg), .vert_x(v2x), .vert_y(v2y)
    );

    // The fourth corner completes the parallelogram before saturation.
    always_comb begin
        px[0] = sat(EW'(v0x));
        py[0] = sat(EW'(v0y));
        px[1] = sat(EW'(v1x));
        py[1] = sat(EW'(v1y));
        px[2] = sat(EW'(v2x));
        py[2] = sat(EW'(v2y));
        px[3] = sat(EW'(v0x) + (EW'(v2x) - EW'(v1x)));
        py[3] = sat(EW'(v2y) - (EW'(v1y) - EW'(v0y)));
        lox_next = start_reg ? CMAX : lox_reg;
        hix_next = start_reg ? CMIN : hix_reg;
        loy_next = start_reg ? CMAX : loy_reg;
        hiy_next = start_reg ? CMIN : hiy_reg;
        for (int k = 0; k < 4; k++) begin
            if (px[k] < lox_next) lox_next = px[k];
            if (px[k] > hix_next) hix_next = px[k];
            if (py[k] < loy_next) loy_next = py[k];
            if (py[k] > hiy_next) hiy_next = py[k];
        end
    end

    always_comb begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_CORDIC;
            end
            S_CORDIC: begin
                wait_next = '0;
                if (cordic_done) state_next = S_LANE;
            end
            S_LANE: begin
                wait_next = wait_reg + 2'd1;
                if (wait_reg == 2'd3) state_next = S_MERGE;
            end
            S_MERGE: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            start_reg <= s_start_new;
            c0x_reg   <= s_corner0_x;
            c0y_reg   <= s_corner0_y;
            c1x_reg   <= s_corner1_x;
            c1y_reg   <= s_corner1_y;
            c2x_reg   <= s_corner2_x;
            c2y_reg   <= s_corner2_y;
            scale_reg <= s_size_scale;
            cenx_reg  <= s_center_x;
            ceny_reg  <= s_center_y;
            angle_reg <= s_turn_angle;
        end
        if (load_out) begin
            mlox_reg <= lox_reg;
            mhix_reg <= hix_reg;
            mloy_reg <= loy_reg;
            mhiy_reg <= hiy_reg;
        end
        wait_reg <= wait_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            lox_reg     <= CMAX;
            hix_reg     <= CMIN;
            loy_reg     <= CMAX;
            hiy_reg     <= CMIN;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == S_MERGE) begin
                lox_reg <= lox_next;
                hix_reg <= hix_next;
                loy_reg <= loy_next;
                hiy_reg <= hiy_next;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_min_x = mlox_reg;
    assign m_max_x = mhix_reg;
    assign m_min_y = mloy_reg;
    assign m_max_y = mhiy_reg;

    `RQBB_ASSERT_NEXT(a_accept_starts, accept, state_reg == S_CORDIC)
    `RQBB_ASSERT_NOW(a_done_in_cordic, cordic_done, state_reg == S_CORDIC)
    `RQBB_ASSERT_NOW(a_box_ordered, state_reg == S_OUT, lox_reg <= hix_reg && loy_reg <= hiy_reg)
    `RQBB_ASSERT_NEXT(a_angle_held, state_reg != S_IDLE, $stable(angle_reg))

endmodule

// ===== bench/tb_rotated_quad_bounding_box.sv =====
// Testbench for the rotated quad bounding box: random sprites, a local predictor and checks.
module tb_rotated_quad_bounding_box;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 24;
    localparam int AW = 16;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint SCALED_LIM = 64'sd1 <<< 47;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1250;

    typedef struct {
        logic             start_new;
        logic [CW-1:0]    cx [3];
        logic [CW-1:0]    cy [3];
        logic [15:0]      scale;
        logic [CW-1:0]    pos_x;
        logic [CW-1:0]    pos_y;
        logic [AW-1:0]    angle;
    } sprite_t;

    typedef struct {
        logic [CW-1:0] min_x, max_x, min_y, max_y;
    } box_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_start_new = 1'b0;
    logic signed [CW-1:0] s_corner0_x = '0, s_corner0_y = '0;
    logic signed [CW-1:0] s_corner1_x = '0, s_corner1_y = '0;
    logic signed [CW-1:0] s_corner2_x = '0, s_corner2_y = '0;
    logic [15:0] s_size_scale = '0;
    logic signed [CW-1:0] s_center_x = '0, s_center_y = '0;
    logic [AW-1:0] s_turn_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_min_x, m_max_x, m_min_y, m_max_y;

    rotated_quad_bounding_box #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    sprite_t pending_sprites[$];
    box_t expected_boxes[$];
    longint run_lo_x = CMAX, run_hi_x = CMIN, run_lo_y = CMAX, run_hi_y = CMIN;
    int errors = 0;
    int boxes_seen = 0;
    int sprites_sent = 0;
    bit stimulus_done = 0;
    bit hold_sender = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int idle_cycles = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // CORDIC in rotation mode over the low 30 bits of the angle in turns,
    // then a quadrant rotation by the top two bits.
    function automatic void rotation_pair(logic [AW-1:0] ang, output longint co,
                                          output longint si);
        longint t, z, x, y, dx, dy, c, s;
        longint atan_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861};
        int quad;
        t = longint'(ang) << (32 - AW);
        quad = int'((t >> 30) & 3);
        z = t & 64'h3FFF_FFFF;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = clip((x + 16384) >>> 15, -32768, 32768);
        s = clip((y + 16384) >>> 15, -32768, 32768);
        case (quad)
            0: begin co = c; si = s; end
            1: begin co = -s; si = c; end
            2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic longint scaled(logic [CW-1:0] raw, logic [15:0] sc);
        longint v;
        v = longint'($signed(raw)) * longint'(sc) + 128;
        return clip(v >>> 8, -SCALED_LIM, SCALED_LIM);
    endfunction

    function automatic void grow_box(longint x, longint y);
        x = clip(x, CMIN, CMAX);
        y = clip(y, CMIN, CMAX);
        if (x < run_lo_x) run_lo_x = x;
        if (x > run_hi_x) run_hi_x = x;
        if (y < run_lo_y) run_lo_y = y;
        if (y > run_hi_y) run_hi_y = y;
    endfunction

    function automatic box_t predict_box(sprite_t sp);
        longint co, si, lx, ly, px, py;
        longint vx [4], vy [4];
        box_t b;
        rotation_pair(sp.angle, co, si);
        px = longint'($signed(sp.pos_x));
        py = longint'($signed(sp.pos_y));
        if (sp.start_new) begin
            run_lo_x = CMAX; run_hi_x = CMIN; run_lo_y = CMAX; run_hi_y = CMIN;
        end
        for (int k = 0; k < 3; k++) begin
            lx = scaled(sp.cx[k], sp.scale);
            ly = scaled(sp.cy[k], sp.scale);
            vx[k] = ((co * lx - si * ly + 16384) >>> 15) + px;
            vy[k] = ((si * lx + co * ly + 16384) >>> 15) + py;
        end
        // Fourth corner completes the parallelogram.
        vx[3] = vx[0] + (vx[2] - vx[1]);
        vy[3] = vy[2] - (vy[1] - vy[0]);
        for (int k = 0; k < 4; k++) grow_box(vx[k], vy[k]);
        b.min_x = run_lo_x[CW-1:0];
        b.max_x = run_hi_x[CW-1:0];
        b.min_y = run_lo_y[CW-1:0];
        b.max_y = run_hi_y[CW-1:0];
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        errors++;
        $display("box %0d: %s got %0d expected %0d", boxes_seen, what,
                 $signed(got), $signed(want));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return CMAX[CW-1:0];
            1: return CMIN[CW-1:0];
            2: return CW'($urandom());
            default: return CW'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic sprite_t random_sprite();
        sprite_t sp;
        sp.start_new = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < 3; k++) begin
            sp.cx[k] = pick_coord();
            sp.cy[k] = pick_coord();
        end
        sp.scale = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
        sp.pos_x = pick_coord();
        sp.pos_y = pick_coord();
        sp.angle = AW'($urandom());
        return sp;
    endfunction

    function automatic sprite_t plain_sprite(logic sn, longint half, logic [15:0] sc,
                                             longint px, longint py, logic [AW-1:0] ang);
        sprite_t sp;
        sp.start_new = sn;
        sp.cx[0] = CW'(-half); sp.cy[0] = CW'(-half);
        sp.cx[1] = CW'(half);  sp.cy[1] = CW'(-half);
        sp.cx[2] = CW'(half);  sp.cy[2] = CW'(half);
        sp.scale = sc;
        sp.pos_x = CW'(px);
        sp.pos_y = CW'(py);
        sp.angle = ang;
        return sp;
    endfunction

    // Driver: presents queued sprites, holding each until it is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                void'(pending_sprites.pop_front());
                sprites_sent++;
                send_gap = pick_gap();
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0 || hold_sender || pending_sprites.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    s_valid      <= 1'b1;
                    s_start_new  <= pending_sprites[0].start_new;
                    s_corner0_x  <= pending_sprites[0].cx[0];
                    s_corner0_y  <= pending_sprites[0].cy[0];
                    s_corner1_x  <= pending_sprites[0].cx[1];
                    s_corner1_y  <= pending_sprites[0].cy[1];
                    s_corner2_x  <= pending_sprites[0].cx[2];
                    s_corner2_y  <= pending_sprites[0].cy[2];
                    s_size_scale <= pending_sprites[0].scale;
                    s_center_x   <= pending_sprites[0].pos_x;
                    s_center_y   <= pending_sprites[0].pos_y;
                    s_turn_angle <= pending_sprites[0].angle;
                end
            end
        end
    end

    // Monitor: predicts from the pins on each accepted input beat, checks each output beat.
    always @(posedge aclk) begin
        box_t want;
        sprite_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.start_new = s_start_new;
                seen.cx[0] = s_corner0_x;
                seen.cy[0] = s_corner0_y;
                seen.cx[1] = s_corner1_x;
                seen.cy[1] = s_corner1_y;
                seen.cx[2] = s_corner2_x;
                seen.cy[2] = s_corner2_y;
                seen.scale = s_size_scale;
                seen.pos_x = s_center_x;
                seen.pos_y = s_center_y;
                seen.angle = s_turn_angle;
                expected_boxes.push_back(predict_box(seen));
            end
            if (m_valid && m_ready) begin
                boxes_seen++;
                if (expected_boxes.size() == 0) begin
                    errors++;
                    $display("unexpected output beat %0d", boxes_seen);
                end else begin
                    want = expected_boxes.pop_front();
                    if (m_min_x !== want.min_x) report_mismatch("min_x", m_min_x, want.min_x);
                    if (m_max_x !== want.max_x) report_mismatch("max_x", m_max_x, want.max_x);
                    if (m_min_y !== want.min_y) report_mismatch("min_y", m_min_y, want.min_y);
                    if (m_max_y !== want.max_y) report_mismatch("max_y", m_max_y, want.max_y);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sprites: reset box, every quadrant, zero and full scale, extremes.
        pending_sprites.push_back(plain_sprite(1'b0, 256, 16'h0100, 0, 0, 16'h0000));
        pending_sprites.push_back(plain_sprite(1'b0, 512, 16'h0100, 1000, -1000, 16'h4000));
        pending_sprites.push_back(plain_sprite(1'b0, 512, 16'h0080, -5000, 5000, 16'h8000));
        pending_sprites.push_back(plain_sprite(1'b1, 300, 16'h0100, 0, 0, 16'hC000));
        pending_sprites.push_back(plain_sprite(1'b1, 300, 16'h0100, 0, 0, 16'h2000));
        pending_sprites.push_back(plain_sprite(1'b1, 300, 16'h0000, 77, -77, 16'hFFFF));
        pending_sprites.push_back(plain_sprite(1'b1, 300, 16'hFFFF, 0, 0, 16'h1234));
        pending_sprites.push_back(plain_sprite(1'b1, CMAX, 16'hFFFF, CMAX, CMAX, 16'h0001));
        pending_sprites.push_back(plain_sprite(1'b1, CMAX, 16'hFFFF, CMIN, CMIN, 16'h6000));
        pending_sprites.push_back(plain_sprite(1'b1, 1000, 16'h0100, CMAX, CMIN, 16'hE000));
        pending_sprites.push_back(plain_sprite(1'b0, CMIN, 16'hFFFF, CMIN, CMAX, 16'hA000));
        pending_sprites.push_back(plain_sprite(1'b1, -1, 16'h0001, -1, -1, 16'h3FFF));
        pending_sprites.push_back(plain_sprite(1'b0, 0, 16'h0100, 12345, -6789, 16'h4001));

        // Pause the sender until the block has drained once. The short delay lets
        // the monitor record the last accepted beat before the queue is checked.
        wait (pending_sprites.size() == 0);
        hold_sender = 1;
        #1;
        wait (expected_boxes.size() == 0);
        @(posedge aclk);
        hold_sender = 0;

        for (int i = 0; i < N_RANDOM; i++) begin
            pending_sprites.push_back(random_sprite());
            // Long runs without a box reset, so saturation and the running merge matter.
            if (i == N_RANDOM / 2) wait (pending_sprites.size() < 4);
        end

        wait (pending_sprites.size() == 0);
        #1;
        wait (expected_boxes.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Sent %0d sprites and checked %0d boxes, covering all quadrants,",
                 sprites_sent, boxes_seen);
        $display("box resets, scale and coordinate extremes and random handshake gaps.");
        if (errors == 0 && expected_boxes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
